/* rtl/gbn_pkg.sv */
// shared types and constants of the go-back-n sender window
// no dependencies; compiled before every other file
package gbn_pkg;

    localparam int WINDOW_SIZE = 3;
    localparam int SEQ_SPACE   = 4;
    localparam int SEQ_W       = $clog2(SEQ_SPACE);
    localparam int PAY_W       = 32;
    localparam int OP_W        = 2;
    localparam int TMR_W       = 2;

    // largest number of packets in flight
    localparam int WIN_LIMIT = (WINDOW_SIZE < SEQ_SPACE - 1) ? WINDOW_SIZE : SEQ_SPACE - 1;
    localparam logic [SEQ_W-1:0] WIN_LIMIT_V = SEQ_W'(WIN_LIMIT);

    typedef enum logic [OP_W-1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2
    } op_t;

    typedef enum logic [TMR_W-1:0] {
        TMR_NONE    = 2'd0,
        TMR_START   = 2'd1,
        TMR_STOP    = 2'd2,
        TMR_RESTART = 2'd3
    } tmr_cmd_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RESEND = 1'b1
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic take;         // load the result of an accepted item
        logic emit_resend;  // load the next retransmission
    } gbn_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;     // output register empty or draining this cycle
        logic start_resend; // offered item is a timeout with more than one packet out
        logic resend_last;  // retransmission at hand is the last (newest) one of the burst
    } gbn_stat_t;

endpackage

/* rtl/gbn_if.sv */
// valid/ready channel interfaces for items and results
// depends on gbn_pkg for field widths
interface gbn_item_if import gbn_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  op;
    logic [PAY_W-1:0] payload_word;
    logic [SEQ_W-1:0] ack_number;
    logic             ack_valid;

    modport source (output valid, op, payload_word, ack_number, ack_valid, input ready);
    modport sink   (input valid, op, payload_word, ack_number, ack_valid, output ready);
endinterface

interface gbn_result_if import gbn_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              accepted;
    logic              has_packet;
    logic [SEQ_W-1:0]  packet_seq;
    logic [PAY_W-1:0]  packet_payload;
    logic [TMR_W-1:0]  timer_cmd;
    logic [SEQ_W-1:0]  window_base;
    logic              last;

    modport source (output valid, accepted, has_packet, packet_seq, packet_payload,
                    timer_cmd, window_base, last, input ready);
    modport sink   (input valid, accepted, has_packet, packet_seq, packet_payload,
                    timer_cmd, window_base, last, output ready);
endinterface

/* rtl/go_back_n_sender_window_core.sv */
// go-back-n arq sender window core over gbn_ctrl and gbn_dp, using gbn_pkg and gbn_if
// a result is valid in the output register in the cycle after its item transfer
// each send, ack or unused op gives one result; a timeout with n > 0 packets out gives n
//   retransmissions, oldest first, with input ready low until the last one is loaded;
//   a receiver hold-off stalls items and retransmissions alike
// reset (rst_n low, async): sequences, resend state and output valid cleared, store kept
module go_back_n_sender_window_core import gbn_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    gbn_item_if.sink    item,
    gbn_result_if.source result
);

    // command and status between sequencer and datapath
    gbn_cmd_t  cmd;
    gbn_stat_t stat;

    // controller: idle takes items, resend state walks the outstanding packets
    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath: window registers, payload store and the output result register,
    // which lets the next transfer in while the waiting result is taken downstream
    gbn_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .op             (item.op),
        .payload_word   (item.payload_word),
        .ack_number     (item.ack_number),
        .ack_valid      (item.ack_valid),
        .out_ready      (result.ready),
        .out_valid      (result.valid),
        .accepted       (result.accepted),
        .has_packet     (result.has_packet),
        .packet_seq     (result.packet_seq),
        .packet_payload (result.packet_payload),
        .timer_cmd      (result.timer_cmd),
        .window_base    (result.window_base),
        .last           (result.last)
    );

endmodule

/* rtl/gbn_ctrl.sv */
// controller state machine: idle or walking a retransmission burst
// depends on gbn_pkg
module gbn_ctrl import gbn_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  gbn_stat_t stat,
    output gbn_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && stat.out_free && stat.start_resend)
                begin
                    state_next = ST_RESEND;
                end
            end
            ST_RESEND:
            begin
                if (stat.out_free && stat.resend_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready         = 1'b0;
        cmd.take         = 1'b0;
        cmd.emit_resend  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = stat.out_free;
                cmd.take = in_valid && stat.out_free;
            end
            ST_RESEND:
            begin
                cmd.emit_resend = stat.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* rtl/gbn_dp.sv */
// datapath: sequence registers, payload store, resend index, result register
// depends on gbn_pkg
module gbn_dp import gbn_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  gbn_cmd_t          cmd,
    output gbn_stat_t         stat,
    input  logic [OP_W-1:0]   op,
    input  logic [PAY_W-1:0]  payload_word,
    input  logic [SEQ_W-1:0]  ack_number,
    input  logic              ack_valid,
    input  logic              out_ready,
    output logic              out_valid,
    output logic              accepted,
    output logic              has_packet,
    output logic [SEQ_W-1:0]  packet_seq,
    output logic [PAY_W-1:0]  packet_payload,
    output logic [TMR_W-1:0]  timer_cmd,
    output logic [SEQ_W-1:0]  window_base,
    output logic              last
);

    logic [SEQ_W-1:0] base_reg, base_next;
    logic [SEQ_W-1:0] nseq_reg, nseq_next;
    logic [SEQ_W-1:0] idx_reg, idx_next;
    logic             vld_reg, vld_next;
    logic [PAY_W-1:0] store_reg [SEQ_SPACE];

    logic             acc_reg, acc_next;
    logic             hp_reg, hp_next;
    logic [SEQ_W-1:0] seq_reg, seq_next;
    logic [PAY_W-1:0] pay_reg, pay_next;
    tmr_cmd_t         tmr_reg, tmr_next;
    logic             last_reg, last_next;

    logic [SEQ_W-1:0] cnt;
    logic [SEQ_W-1:0] ack_base;
    logic [SEQ_W-1:0] ack_dist;
    logic [SEQ_W-1:0] rd_seq;
    logic [SEQ_W-1:0] idx_inc;
    logic             load;
    logic             store_we;

    assign cnt      = nseq_reg - base_reg;
    assign ack_base = ack_number + SEQ_W'(1);
    assign ack_dist = ack_base - base_reg;
    assign idx_inc  = idx_reg + SEQ_W'(1);
    assign rd_seq   = cmd.take ? base_reg : base_reg + idx_reg;
    assign load     = cmd.take || cmd.emit_resend;

    assign stat.out_free     = !vld_reg || out_ready;
    assign stat.start_resend = (op == OP_TIMEOUT) && (cnt > SEQ_W'(1));
    assign stat.resend_last  = (idx_inc == cnt);

    assign store_we = cmd.take && (op == OP_SEND) && (cnt < WIN_LIMIT_V);

    always_comb
    begin
        base_next = base_reg;
        nseq_next = nseq_reg;
        idx_next  = idx_reg;
        acc_next  = acc_reg;
        hp_next   = hp_reg;
        seq_next  = seq_reg;
        pay_next  = pay_reg;
        tmr_next  = tmr_reg;
        last_next = last_reg;
        vld_next  = vld_reg && !out_ready;
        if (load)
        begin
            vld_next = 1'b1;
        end

        if (cmd.take)
        begin
            acc_next  = 1'b0;
            hp_next   = 1'b0;
            seq_next  = '0;
            pay_next  = '0;
            tmr_next  = TMR_NONE;
            last_next = 1'b1;
            idx_next  = SEQ_W'(1);
            case (op)
                OP_SEND:
                begin
                    if (cnt < WIN_LIMIT_V)
                    begin
                        acc_next  = 1'b1;
                        hp_next   = 1'b1;
                        seq_next  = nseq_reg;
                        pay_next  = payload_word;
                        tmr_next  = (cnt == '0) ? TMR_START : TMR_NONE;
                        nseq_next = nseq_reg + SEQ_W'(1);
                    end
                end
                OP_ACK:
                begin
                    if (ack_valid && (ack_dist <= cnt))
                    begin
                        base_next = ack_base;
                        tmr_next  = (ack_base == nseq_reg) ? TMR_STOP : TMR_RESTART;
                    end
                end
                OP_TIMEOUT:
                begin
                    tmr_next = TMR_RESTART;
                    if (cnt != '0)
                    begin
                        hp_next   = 1'b1;
                        seq_next  = rd_seq;
                        pay_next  = store_reg[rd_seq];
                        last_next = (cnt == SEQ_W'(1));
                    end
                end
                default:
                begin
                    last_next = 1'b1;
                end
            endcase
        end
        else if (cmd.emit_resend)
        begin
            acc_next  = 1'b0;
            hp_next   = 1'b1;
            seq_next  = rd_seq;
            pay_next  = store_reg[rd_seq];
            tmr_next  = TMR_NONE;
            last_next = (idx_inc == cnt);
            idx_next  = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= '0;
            nseq_reg <= '0;
            idx_reg  <= '0;
            vld_reg  <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            nseq_reg <= nseq_next;
            idx_reg  <= idx_next;
            vld_reg  <= vld_next;
        end
    end

    // payload and result fields carry no reset
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        hp_reg   <= hp_next;
        seq_reg  <= seq_next;
        pay_reg  <= pay_next;
        tmr_reg  <= tmr_next;
        last_reg <= last_next;
        if (store_we)
        begin
            store_reg[nseq_reg] <= payload_word;
        end
    end

    // base of the result register: base after the item that produced it
    logic [SEQ_W-1:0] wb_reg, wb_next;

    always_comb
    begin
        wb_next = wb_reg;
        if (load)
        begin
            wb_next = base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        wb_reg <= wb_next;
    end

    assign out_valid      = vld_reg;
    assign accepted       = acc_reg;
    assign has_packet     = hp_reg;
    assign packet_seq     = seq_reg;
    assign packet_payload = pay_reg;
    assign timer_cmd      = tmr_reg;
    assign window_base    = wb_reg;
    assign last           = last_reg;

endmodule

/* tb/gbn_checker.sv */
// result checker for the go-back-n sender window: predicts every result
// from the item transfers it watches and compares the result transfers
// depends on gbn_pkg and the channel interfaces in gbn_if
module gbn_checker import gbn_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    gbn_item_if   item,
    gbn_result_if result,
    output int    fail_count,
    output int    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic             accepted;
        logic             has_packet;
        logic [SEQ_W-1:0] seq;
        logic [PAY_W-1:0] payload;
        tmr_cmd_t         timer;
        logic [SEQ_W-1:0] base;
        logic             last;
    } tx_result_t;

    tx_result_t       tx_expected_q[$];
    logic [PAY_W-1:0] sent_payload [SEQ_SPACE];
    logic [SEQ_W-1:0] base_seq;
    logic [SEQ_W-1:0] next_seq;
    int               mismatches;

    // sequence space is a power of two, so plain subtraction wraps modulo SEQ_SPACE
    function automatic void predict_item(logic [OP_W-1:0] op, logic [PAY_W-1:0] pay,
                                         logic [SEQ_W-1:0] ack, logic ack_ok);
        logic [SEQ_W-1:0] in_flight;
        logic [SEQ_W-1:0] new_base;
        tx_result_t       r;
        int               k;
        in_flight = next_seq - base_seq;
        r = '0;
        r.timer = TMR_NONE;
        r.last = 1'b1;
        case (op)
            OP_SEND:
            begin
                if (in_flight < WIN_LIMIT_V)
                begin
                    sent_payload[next_seq] = pay;
                    r.accepted = 1'b1;
                    r.has_packet = 1'b1;
                    r.seq = next_seq;
                    r.payload = pay;
                    r.timer = (in_flight == '0) ? TMR_START : TMR_NONE;
                    next_seq = next_seq + SEQ_W'(1);
                end
            end
            OP_ACK:
            begin
                new_base = ack + SEQ_W'(1);
                if (ack_ok && (new_base - base_seq) <= in_flight)
                begin
                    base_seq = new_base;
                    r.timer = (base_seq == next_seq) ? TMR_STOP : TMR_RESTART;
                end
            end
            OP_TIMEOUT:
            begin
                if (in_flight == '0)
                begin
                    r.timer = TMR_RESTART;
                end
                else
                begin
                    // oldest first, restart only on the first retransmission
                    for (k = 0; k < int'(in_flight); k++)
                    begin
                        r.has_packet = 1'b1;
                        r.seq = base_seq + SEQ_W'(k);
                        r.payload = sent_payload[r.seq];
                        r.timer = (k == 0) ? TMR_RESTART : TMR_NONE;
                        r.base = base_seq;
                        r.last = (k == int'(in_flight) - 1);
                        tx_expected_q = {tx_expected_q, r};
                    end
                    return;
                end
            end
            default:
            begin
            end
        endcase
        r.base = base_seq;
        tx_expected_q = {tx_expected_q, r};
    endfunction

    function automatic int compare_result(tx_result_t want, tx_result_t got);
        int bad;
        bad = 0;
        if (got.accepted !== want.accepted)
        begin
            $error("accepted: expected %0d, got %0d", want.accepted, got.accepted);
            bad++;
        end
        if (got.has_packet !== want.has_packet)
        begin
            $error("has_packet: expected %0d, got %0d", want.has_packet, got.has_packet);
            bad++;
        end
        if (got.seq !== want.seq)
        begin
            $error("packet_seq: expected %0d, got %0d", want.seq, got.seq);
            bad++;
        end
        if (got.payload !== want.payload)
        begin
            $error("packet_payload: expected %h, got %h", want.payload, got.payload);
            bad++;
        end
        if (got.timer !== want.timer)
        begin
            $error("timer_cmd: expected %0d, got %0d", want.timer, got.timer);
            bad++;
        end
        if (got.base !== want.base)
        begin
            $error("window_base: expected %0d, got %0d", want.base, got.base);
            bad++;
        end
        if (got.last !== want.last)
        begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            bad++;
        end
        return bad;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tx_result_t got;
        tx_result_t want;
        if (!rst_n)
        begin
            base_seq = '0;
            next_seq = '0;
            mismatches = 0;
            tx_expected_q.delete();
            pending <= 0;
            fail_count <= 0;
        end
        else
        begin
            // a result never belongs to the item taken at the same edge
            if (result.valid && result.ready)
            begin
                got.accepted = result.accepted;
                got.has_packet = result.has_packet;
                got.seq = result.packet_seq;
                got.payload = result.packet_payload;
                got.timer = tmr_cmd_t'(result.timer_cmd);
                got.base = result.window_base;
                got.last = result.last;
                if (tx_expected_q.size() == 0)
                begin
                    $error("unexpected result transfer: packet_seq %0d, packet_payload %h",
                           got.seq, got.payload);
                    mismatches++;
                end
                else
                begin
                    want = tx_expected_q[0];
                    tx_expected_q.delete(0);
                    mismatches += compare_result(want, got);
                end
            end
            if (item.valid && item.ready)
            begin
                predict_item(item.op, item.payload_word, item.ack_number, item.ack_valid);
            end
            pending <= tx_expected_q.size();
            fail_count <= mismatches;
        end
    end

endmodule

/* tb/tb_top.sv */
// top of the go-back-n sender window bench: clock, reset, item and result traffic
// and the verdict; checking lives in gbn_checker
// depends on gbn_pkg, gbn_if, gbn_checker and go_back_n_sender_window_core
module tb_top import gbn_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    // op code the block does not define, still reachable through the 2-bit field
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_ITEMS     = 340;
    localparam int SINK_HOLD_CYCLES = 60;
    // far above the worst quiet stretch: long receiver hold plus a timeout burst
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 4;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    // traffic shaping flags, set by the stimulus process
    logic sink_hold_req;  // receiver takes one long hold-off when it sees this
    logic burst_phase;    // sender offers back to back
    logic steady_phase;   // neither side idles

    gbn_item_if   item_ch();
    gbn_result_if result_ch();

    go_back_n_sender_window_core DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    gbn_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item_ch),
        .result     (result_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // sender idle length: mostly none or short, now and then a long one
    function automatic int sender_gap();
        int roll;
        if (burst_phase || steady_phase)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    // offer one item and return at the edge where its transfer happens;
    // entered and left on a rising edge, one assignment to valid per edge
    task automatic push_item(logic [OP_W-1:0] op, logic [PAY_W-1:0] pay,
                             logic [SEQ_W-1:0] ack, logic ack_ok);
        int gap;
        gap = sender_gap();
        if (gap > 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.op           <= op;
        item_ch.payload_word <= pay;
        item_ch.ack_number   <= ack;
        item_ch.ack_valid    <= ack_ok;
        do @(posedge clk); while (!item_ch.ready);
    endtask

    // mostly sends and acks that keep the window moving, some timeouts,
    // a few corrupt acks and unused op codes as noise
    task automatic random_item();
        int               roll;
        logic [OP_W-1:0]  op;
        logic [PAY_W-1:0] pay;
        logic [SEQ_W-1:0] ack;
        logic             ack_ok;
        roll   = $urandom_range(0, 99);
        pay    = $urandom;
        ack    = SEQ_W'($urandom_range(0, 3));
        ack_ok = ($urandom_range(0, 9) != 0);
        if (roll < 42)
            op = OP_SEND;
        else if (roll < 77)
            op = OP_ACK;
        else if (roll < 93)
            op = OP_TIMEOUT;
        else
            op = OP_UNUSED;
        push_item(op, pay, ack, ack_ok);
    endtask

    // caller has lowered valid; the count seen here is from the previous edge
    task automatic wait_drained();
        do @(posedge clk); while (pending != 0);
    endtask

    // receiver: holds ready for a random number of cycles, one assignment per edge
    initial
    begin
        int   roll;
        int   hold;
        logic rdy;
        result_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (sink_hold_req)
            begin
                // long hold-off so the output register fills and the input stalls
                sink_hold_req = 1'b0;
                rdy  = 1'b0;
                hold = SINK_HOLD_CYCLES;
            end
            else if (steady_phase)
            begin
                rdy  = 1'b1;
                hold = 1;
            end
            else
            begin
                roll = $urandom_range(0, 99);
                if (roll < 60)
                begin
                    rdy  = 1'b1;
                    hold = $urandom_range(1, 8);
                end
                else if (roll < 92)
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(1, 3);
                end
                else
                begin
                    rdy  = 1'b0;
                    hold = $urandom_range(8, 30);
                end
            end
            result_ch.ready <= rdy;
            repeat (hold) @(posedge clk);
        end
    end

    // watchdog: counts edges with work outstanding and no transfer on either side
    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (!item_ch.valid && pending == 0))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // stimulus and verdict
    initial
    begin
        item_ch.valid        = 1'b0;
        item_ch.op           = OP_SEND;
        item_ch.payload_word = '0;
        item_ch.ack_number   = '0;
        item_ch.ack_valid    = 1'b0;
        sink_hold_req        = 1'b0;
        burst_phase          = 1'b0;
        steady_phase         = 1'b0;
        rst_n                = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty window: timeout gives a bare restart
        push_item(OP_TIMEOUT, 32'h0000_0000, 2'd0, 1'b0);
        // duplicate ack on an empty window still stops the timer
        push_item(OP_ACK,     32'h0000_0000, 2'd3, 1'b1);
        // corrupt ack is ignored
        push_item(OP_ACK,     32'hFFFF_FFFF, 2'd0, 1'b0);
        // ack beyond what was sent is out of the window
        push_item(OP_ACK,     32'h0000_0000, 2'd1, 1'b1);
        // unused op code, every other field at its top value
        push_item(OP_UNUSED,  32'hFFFF_FFFF, 2'd3, 1'b1);
        // fill the window with extreme payloads, the fourth send is refused
        push_item(OP_SEND,    32'h0000_0000, 2'd0, 1'b0);
        push_item(OP_SEND,    32'hFFFF_FFFF, 2'd3, 1'b1);
        push_item(OP_SEND,    32'h5A5A_A5A5, 2'd1, 1'b0);
        push_item(OP_SEND,    32'h1234_5678, 2'd2, 1'b1);
        // full window: three retransmissions
        push_item(OP_TIMEOUT, 32'hFFFF_FFFF, 2'd3, 1'b1);
        // slide by one, then an ack that lies behind the base
        push_item(OP_ACK,     32'h0000_0000, 2'd0, 1'b1);
        push_item(OP_ACK,     32'h0000_0000, 2'd3, 1'b1);
        // duplicate ack with packets out restarts the timer
        push_item(OP_ACK,     32'h0000_0000, 2'd0, 1'b1);
        push_item(OP_ACK,     32'h0000_0000, 2'd2, 1'b0);
        // ack that empties the window stops the timer
        push_item(OP_ACK,     32'h0000_0000, 2'd2, 1'b1);
        // sends across the sequence wrap, then resend them
        push_item(OP_SEND,    32'h3C3C_C3C3, 2'd0, 1'b0);
        push_item(OP_SEND,    32'h8000_0001, 2'd0, 1'b0);
        push_item(OP_SEND,    32'h7FFF_FFFE, 2'd0, 1'b0);
        push_item(OP_TIMEOUT, 32'h0000_0000, 2'd0, 1'b0);
        push_item(OP_ACK,     32'h0000_0000, 2'd0, 1'b1);
        push_item(OP_TIMEOUT, 32'h0000_0000, 2'd0, 1'b0);
        push_item(OP_ACK,     32'h0000_0000, 2'd1, 1'b1);
        push_item(OP_SEND,    32'hDEAD_0000, 2'd0, 1'b0);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == 100)
            begin
                // receiver holds off while the sender keeps offering
                sink_hold_req = 1'b1;
                burst_phase   = 1'b1;
            end
            if (n == 125)
                burst_phase = 1'b0;
            if (n == 200)
            begin
                // sender pauses until every result is out
                item_ch.valid <= 1'b0;
                wait_drained();
            end
            if (n == 250)
                steady_phase = 1'b1;
            if (n == 300)
                steady_phase = 1'b0;
            random_item();
        end

        item_ch.valid <= 1'b0;
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
